// ----- hw/rtl/sd_spi_init_and_block_read_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef SD_SPI_INIT_AND_BLOCK_READ_ASSERT_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDSPI_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sdspi: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDSPI_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sdspi: next-cycle check failed");

`endif

// ----- hw/rtl/sdspi_pkg.sv -----
package sdspi_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CLOCK,
      PH_CMD,
      PH_RESP,
      PH_TAIL,
      PH_TOKEN,
      PH_DATA
   } sdspi_phase_type;

   typedef enum logic [2:0] {
      ST_BUSY,
      ST_INIT_DONE,
      ST_READ_DONE,
      ST_REJECTED,
      ST_TOKEN_TIMEOUT,
      ST_INIT_TIMEOUT
   } sdspi_status_type;

   localparam logic [1:0] ACT_INIT = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_BYTE = 2'd2;

   localparam logic [1:0] CSR_CLOCKING_BYTES = 2'd0;
   localparam logic [1:0] CSR_RESPONSE_POLLS = 2'd1;
   localparam logic [1:0] CSR_TOKEN_POLLS    = 2'd2;
   localparam logic [1:0] CSR_INIT_ATTEMPTS  = 2'd3;

   localparam logic [7:0]  CLOCKING_BYTES_RESET = 8'd80;
   localparam logic [7:0]  RESPONSE_POLLS_RESET = 8'd8;
   localparam logic [15:0] TOKEN_POLLS_RESET    = 16'd2000;
   localparam logic [15:0] INIT_ATTEMPTS_RESET  = 16'd1000;

   localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
   localparam logic [5:0] CMD_SEND_IF    = 6'd8;
   localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
   localparam logic [5:0] CMD_SEND_OP    = 6'd41;
   localparam logic [5:0] CMD_APP        = 6'd55;
   localparam logic [5:0] CMD_READ_OCR   = 6'd58;

   localparam logic [31:0] ARG_SEND_IF = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
   localparam logic [31:0] ARG_NONE    = 32'h0000_0000;

   localparam logic [7:0] CRC_CMD0    = 8'h95;
   localparam logic [7:0] CRC_CMD8    = 8'h87;
   localparam logic [7:0] CRC_END_BIT = 8'h01;
   localparam logic [7:0] START_TOKEN = 8'hFE;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;
   localparam logic [7:0] R1_READY    = 8'h00;
   localparam logic [1:0] CMD_PREFIX  = 2'b01;

   localparam logic [15:0] FRAME_BYTES = 16'd8;
   localparam logic [15:0] TAIL_BYTES  = 16'd4;

   typedef struct packed {
      logic [7:0]  clocking_bytes;
      logic [7:0]  response_polls;
      logic [15:0] token_polls;
      logic [15:0] init_attempts;
   } sdspi_cfg_type;

   typedef struct packed {
      sdspi_phase_type phase;
      logic [5:0]      cmd;
      logic [31:0]     arg;
      logic [15:0]     byte_cnt;
      logic [15:0]     poll_cnt;
      logic [15:0]     attempt_cnt;
   } sdspi_state_type;

   typedef struct packed {
      logic             exchange_request;
      logic [7:0]       mosi_byte;
      logic             chip_select_high;
      logic [7:0]       data_byte;
      logic             data_valid;
      logic             data_last;
      sdspi_status_type status;
   } sdspi_result_type;

   function automatic logic [7:0] sdspi_crc(input logic [5:0] cmd);
      logic [7:0] crc;
      case (cmd)
         CMD_GO_IDLE: crc = CRC_CMD0;
         CMD_SEND_IF: crc = CRC_CMD8;
         default:     crc = CRC_END_BIT;
      endcase
      return crc;
   endfunction

endpackage

// ----- hw/rtl/sdspi_csr.sv -----
module sdspi_csr
   import sdspi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   output sdspi_cfg_type cfg
);

   sdspi_cfg_type cfg_ff;
   sdspi_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLOCKING_BYTES: cfg_in.clocking_bytes = csr_wdata[7:0];
            CSR_RESPONSE_POLLS: cfg_in.response_polls = csr_wdata[7:0];
            CSR_TOKEN_POLLS:    cfg_in.token_polls    = csr_wdata;
            CSR_INIT_ATTEMPTS:  cfg_in.init_attempts  = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clocking_bytes <= CLOCKING_BYTES_RESET;
         cfg_ff.response_polls <= RESPONSE_POLLS_RESET;
         cfg_ff.token_polls    <= TOKEN_POLLS_RESET;
         cfg_ff.init_attempts  <= INIT_ATTEMPTS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/sdspi_step.sv -----
module sdspi_step
   import sdspi_pkg::*;
#(
   parameter int BLOCK_BYTES = 512
)
(
   input  sdspi_cfg_type    cfg,
   input  sdspi_state_type  cur,
   input  logic [1:0]       action,
   input  logic [31:0]      block_address,
   input  logic [7:0]       miso_byte,
   output sdspi_state_type  nxt,
   output sdspi_result_type result
);

   localparam logic [15:0] BlockLast = 16'(BLOCK_BYTES);

   logic             do_start;
   logic [5:0]       start_cmd;
   logic [31:0]      start_arg;
   logic [15:0]      byte_inc;
   logic [15:0]      poll_inc;
   logic [15:0]      attempt_inc;
   sdspi_status_type status;
   logic [7:0]       data_byte;
   logic             data_valid;
   logic             data_last;
   logic             exchange_request;
   logic [7:0]       mosi_byte;
   logic             chip_select_high;

   assign byte_inc    = cur.byte_cnt + 16'd1;
   assign poll_inc    = cur.poll_cnt + 16'd1;
   assign attempt_inc = cur.attempt_cnt + 16'd1;

   always_comb begin : next_state
      nxt        = cur;
      do_start   = 1'b0;
      start_cmd  = CMD_GO_IDLE;
      start_arg  = ARG_NONE;
      status     = ST_BUSY;
      data_byte  = 8'h00;
      data_valid = 1'b0;
      data_last  = 1'b0;
      case (action)
         ACT_INIT: begin
            nxt.attempt_cnt = 16'd0;
            nxt.poll_cnt    = 16'd0;
            if (cfg.clocking_bytes != 8'd0) begin
               nxt.phase    = PH_CLOCK;
               nxt.byte_cnt = 16'd0;
            end else begin
               do_start = 1'b1;
            end
         end
         ACT_READ: begin
            do_start  = 1'b1;
            start_cmd = CMD_READ_BLOCK;
            start_arg = block_address;
         end
         ACT_BYTE: begin
            case (cur.phase)
               PH_CLOCK: begin
                  nxt.byte_cnt = byte_inc;
                  if (byte_inc >= {8'd0, cfg.clocking_bytes}) begin
                     do_start = 1'b1;
                  end
               end
               PH_CMD: begin
                  nxt.byte_cnt = byte_inc;
                  if (byte_inc >= FRAME_BYTES) begin
                     nxt.phase    = PH_RESP;
                     nxt.poll_cnt = 16'd0;
                  end
               end
               PH_RESP: begin
                  nxt.poll_cnt = poll_inc;
                  if (miso_byte != IDLE_BYTE || poll_inc >= {8'd0, cfg.response_polls}) begin
                     case (cur.cmd)
                        CMD_GO_IDLE: begin
                           do_start  = 1'b1;
                           start_cmd = CMD_SEND_IF;
                           start_arg = ARG_SEND_IF;
                        end
                        CMD_SEND_IF: begin
                           if (miso_byte != IDLE_BYTE) begin
                              nxt.phase    = PH_TAIL;
                              nxt.byte_cnt = 16'd0;
                           end else begin
                              do_start  = 1'b1;
                              start_cmd = CMD_APP;
                           end
                        end
                        CMD_APP: begin
                           do_start  = 1'b1;
                           start_cmd = CMD_SEND_OP;
                           start_arg = ARG_HCS;
                        end
                        CMD_SEND_OP: begin
                           if (miso_byte == R1_READY) begin
                              do_start  = 1'b1;
                              start_cmd = CMD_READ_OCR;
                           end else begin
                              nxt.attempt_cnt = attempt_inc;
                              if (attempt_inc >= cfg.init_attempts) begin
                                 nxt.phase = PH_IDLE;
                                 status    = ST_INIT_TIMEOUT;
                              end else begin
                                 do_start  = 1'b1;
                                 start_cmd = CMD_APP;
                              end
                           end
                        end
                        CMD_READ_OCR: begin
                           nxt.phase    = PH_TAIL;
                           nxt.byte_cnt = 16'd0;
                        end
                        default: begin
                           if (miso_byte != R1_READY) begin
                              nxt.phase = PH_IDLE;
                              status    = ST_REJECTED;
                           end else begin
                              nxt.phase    = PH_TOKEN;
                              nxt.poll_cnt = 16'd0;
                           end
                        end
                     endcase
                  end
               end
               PH_TAIL: begin
                  nxt.byte_cnt = byte_inc;
                  if (byte_inc >= TAIL_BYTES) begin
                     if (cur.cmd == CMD_SEND_IF) begin
                        do_start  = 1'b1;
                        start_cmd = CMD_APP;
                     end else begin
                        nxt.phase = PH_IDLE;
                        status    = ST_INIT_DONE;
                     end
                  end
               end
               PH_TOKEN: begin
                  if (miso_byte == START_TOKEN) begin
                     nxt.phase    = PH_DATA;
                     nxt.byte_cnt = 16'd0;
                  end else begin
                     nxt.poll_cnt = poll_inc;
                     if (poll_inc >= cfg.token_polls) begin
                        nxt.phase = PH_IDLE;
                        status    = ST_TOKEN_TIMEOUT;
                     end
                  end
               end
               PH_DATA: begin
                  data_byte    = miso_byte;
                  data_valid   = 1'b1;
                  nxt.byte_cnt = byte_inc;
                  if (byte_inc >= BlockLast) begin
                     data_last = 1'b1;
                     nxt.phase = PH_IDLE;
                     status    = ST_READ_DONE;
                  end
               end
               default: begin
                  nxt = cur;
               end
            endcase
         end
         default: begin
            nxt = cur;
         end
      endcase
      if (do_start) begin
         nxt.phase    = PH_CMD;
         nxt.cmd      = start_cmd;
         nxt.arg      = start_arg;
         nxt.byte_cnt = 16'd0;
      end
   end

   always_comb begin : exchange_out
      exchange_request = 1'b0;
      mosi_byte        = IDLE_BYTE;
      chip_select_high = 1'b1;
      if (nxt.phase != PH_IDLE) begin
         exchange_request = 1'b1;
         chip_select_high = 1'b0;
         case (nxt.phase)
            PH_CLOCK: chip_select_high = 1'b1;
            PH_CMD: begin
               case (nxt.byte_cnt)
                  16'd0:   chip_select_high = 1'b1;
                  16'd2:   mosi_byte = {CMD_PREFIX, nxt.cmd};
                  16'd3:   mosi_byte = nxt.arg[31:24];
                  16'd4:   mosi_byte = nxt.arg[23:16];
                  16'd5:   mosi_byte = nxt.arg[15:8];
                  16'd6:   mosi_byte = nxt.arg[7:0];
                  16'd7:   mosi_byte = sdspi_crc(nxt.cmd);
                  default: mosi_byte = IDLE_BYTE;
               endcase
            end
            default: chip_select_high = 1'b0;
         endcase
      end
   end

   assign result.exchange_request = exchange_request;
   assign result.mosi_byte        = mosi_byte;
   assign result.chip_select_high = chip_select_high;
   assign result.data_byte        = data_byte;
   assign result.data_valid       = data_valid;
   assign result.data_last        = data_last;
   assign result.status           = status;

endmodule

// ----- hw/rtl/sd_spi_init_and_block_read.sv -----
// SD card host in SPI mode, stepped one byte exchange at a time.
// Each request on the req_ channel carries an action in req_tuser: start
// initialization, read one block at req_tdata[31:0], or report the byte the
// card returned (req_tdata[39:32]) in the exchange last asked for.
// Every request produces exactly one response on the rsp_ channel. It tells
// whether to exchange another byte, which byte to send and the chip select
// level; during a block read it carries one data byte (rsp_tuser high,
// rsp_tlast on the final byte) and it reports completion or errors in status.
// A request is registered in the input register on acceptance, and its
// response is then registered in the output register once that is free.
// One request is accepted per cycle while the receiver does not stall, set
// by the combinational state update between the input and output registers.
// When the receiver stalls, the output register holds its response and the
// input register holds one more request; req_tready falls once both are full.
// Synchronous reset empties both registers, returns the sequencer to idle and
// loads the csr_ registers with their defaults. Write csr_ only when idle.
module sd_spi_init_and_block_read
   import sdspi_pkg::*;
#(
   parameter int BLOCK_BYTES = 512
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // block_address[31:0], miso_byte[39:32]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // exchange_request[0], mosi_byte[8:1],
                                   // chip_select_high[9], data_byte[17:10],
                                   // status[20:18], zero fill
   output logic        rsp_tuser,  // data_valid[0]
   output logic        rsp_tlast,  // data_last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   sdspi_cfg_type    cfg;
   sdspi_state_type  state_ff;
   sdspi_state_type  state_in;
   sdspi_result_type result;
   sdspi_result_type out_ff;
   logic             in_valid_ff;
   logic [1:0]       in_action_ff;
   logic [31:0]      in_address_ff;
   logic [7:0]       in_miso_ff;
   logic             out_valid_ff;
   logic             advance;

   sdspi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdspi_step #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_step (
      .cfg           (cfg),
      .cur           (state_ff),
      .action        (in_action_ff),
      .block_address (in_address_ff),
      .miso_byte     (in_miso_ff),
      .nxt           (state_in),
      .result        (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, default: '0};
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff  <= req_tuser;
         in_address_ff <= req_tdata[31:0];
         in_miso_ff    <= req_tdata[39:32];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.status, out_ff.data_byte, out_ff.chip_select_high,
                        out_ff.mosi_byte, out_ff.exchange_request};
   assign rsp_tuser  = out_ff.data_valid;
   assign rsp_tlast  = out_ff.data_last;

endmodule

// ----- hw/rtl/sdspi_checker.sv -----
`include "sd_spi_init_and_block_read_assert.svh"

module sdspi_checker
   import sdspi_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   `SDSPI_ASSERT_IMPLIES(no_data_is_clean, clock, reset, rsp_tvalid && !rsp_tuser, !rsp_tlast && rsp_tdata[17:10] == 8'h00)
   `SDSPI_ASSERT_IMPLIES(idle_line_is_quiet, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[8:1] == IDLE_BYTE && rsp_tdata[9])
   `SDSPI_ASSERT_IMPLIES(last_ends_read, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser && rsp_tdata[20:18] == ST_READ_DONE && !rsp_tdata[0])
   `SDSPI_ASSERT_IMPLIES(status_means_done, clock, reset, rsp_tvalid && rsp_tdata[20:18] != ST_BUSY, !rsp_tdata[0])
   `SDSPI_ASSERT_NEXT(stall_holds_valid, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

endmodule

bind sd_spi_init_and_block_read sdspi_checker u_sdspi_checker (.*);
